// ----- src/wrsd_pkg.sv -----
// shared types and constants for the windowed rssi spread detector
package wrsd_pkg;

    localparam logic signed [7:0] RSSI_FLOOR = -8'sd100;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_TENTHS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION_SCANS = 1'b1;

    localparam logic [9:0] THRESHOLD_RST = 10'd45;
    localparam logic [7:0] CAL_SCANS_RST = 8'd10;

    localparam logic [19:0] SPREAD_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        STATUS_CAL    = 2'd0,
        STATUS_NORMAL = 2'd1,
        STATUS_ALERT  = 2'd2
    } status_t;

    // scan-end request into the window store
    typedef struct packed {
        logic              start;
        logic signed [7:0] peak;
    } win_ctl_t;

    // result of the spread evaluation
    typedef struct packed {
        logic        done;
        logic        alert;
        logic [19:0] spread;
    } eval_res_t;

endpackage

// ----- src/wrsd_ram.sv -----
// generic single-port-write ram with registered read
module wrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/wrsd_window.sv -----
// ring of scan peaks in ram with running count, sum and sum of squares
module wrsd_window #(
    parameter int WINDOW = 15,
    localparam int CW = $clog2(WINDOW + 1),
    localparam int PW = $clog2(WINDOW),
    localparam int SUMW = 8 + CW,
    localparam int SQW = 14 + CW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wrsd_pkg::win_ctl_t     ctl,
    output logic                   done,
    output logic [CW-1:0]          count,
    output logic signed [SUMW-1:0] sum,
    output logic [SQW-1:0]         sq
);

    logic [2:0]            stage_reg;
    logic [PW-1:0]         wp_reg;
    logic [WINDOW-1:0]     vld_reg;
    logic signed [7:0]     peak_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [SQW-1:0]        sq_reg;
    logic [14:0]           sq_old_reg;
    logic [14:0]           sq_new_reg;

    logic [7:0]            rd_data;
    logic signed [7:0]     old_val;
    logic                  old_ok;
    logic                  new_ok;
    logic signed [15:0]    old_sq;
    logic signed [15:0]    new_sq;
    logic                  step1;

    assign step1 = stage_reg[0];

    // the entry is read at the scan-end beat and written in the cycle after it;
    // the next read of the ring comes only after the window update is done
    wrsd_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (step1),
        .waddr (wp_reg),
        .wdata (peak_reg),
        .re    (ctl.start),
        .raddr (wp_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        old_val = $signed(rd_data);
        old_ok  = vld_reg[wp_reg] && (old_val > wrsd_pkg::RSSI_FLOOR);
        new_ok  = peak_reg > wrsd_pkg::RSSI_FLOOR;
        old_sq  = old_val * old_val;
        new_sq  = peak_reg * peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            wp_reg    <= '0;
            vld_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], ctl.start};
            if (step1)
            begin
                vld_reg[wp_reg] <= 1'b1;
                wp_reg  <= (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                cnt_reg <= cnt_reg - CW'(old_ok) + CW'(new_ok);
                sum_reg <= sum_reg - (old_ok ? SUMW'(old_val) : SUMW'(0))
                                   + (new_ok ? SUMW'(peak_reg) : SUMW'(0));
            end
            if (stage_reg[1])
            begin
                sq_reg <= sq_reg - SQW'(sq_old_reg) + SQW'(sq_new_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            peak_reg <= ctl.peak;
        end
        if (step1)
        begin
            sq_old_reg <= old_ok ? old_sq[14:0] : '0;
            sq_new_reg <= new_ok ? new_sq[14:0] : '0;
        end
    end

    assign done  = stage_reg[2];
    assign count = cnt_reg;
    assign sum   = sum_reg;
    assign sq    = sq_reg;

endmodule

// ----- src/wrsd_eval.sv -----
// spread n*s2 - s1^2 and the squared threshold test, four register stages
module wrsd_eval #(
    parameter int WINDOW = 15,
    localparam int CW = $clog2(WINDOW + 1),
    localparam int SUMW = 8 + CW,
    localparam int SQW = 14 + CW,
    localparam int DW = 2 * SUMW,
    localparam int CMPW = DW + 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CW-1:0]           count,
    input  logic signed [SUMW-1:0]  sum,
    input  logic [SQW-1:0]          sq,
    input  logic [9:0]              threshold,
    output wrsd_pkg::eval_res_t     res
);

    logic [3:0]            stage_reg;
    logic [CW+SQW-1:0]     prod_a_reg;
    logic [DW-1:0]         prod_b_reg;
    logic [19:0]           t2_reg;
    logic [2*CW-1:0]       n2_reg;
    logic [DW-1:0]         d_reg;
    logic [CMPW-1:0]       lhs_reg;
    logic [CMPW-1:0]       rhs_reg;
    logic                  alert_reg;

    logic [CW+SQW-1:0]     prod_a;
    logic signed [DW-1:0]  prod_b;
    logic [19:0]           t2;
    logic [2*CW-1:0]       n2;
    logic signed [DW:0]    diff;
    logic [20+2*CW-1:0]    tn;

    always_comb
    begin
        prod_a = count * sq;
        prod_b = sum * sum;
        t2     = threshold * threshold;
        n2     = count * count;
        diff   = $signed({1'b0, DW'(prod_a_reg)}) - $signed({1'b0, prod_b_reg});
        tn     = t2_reg * n2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            t2_reg     <= t2;
            n2_reg     <= n2;
        end
        if (stage_reg[0])
        begin
            // clamp a negative difference to zero
            d_reg <= diff[DW] ? '0 : diff[DW-1:0];
        end
        if (stage_reg[1])
        begin
            // 100 * d as shifts
            lhs_reg <= (CMPW'(d_reg) << 6) + (CMPW'(d_reg) << 5) + (CMPW'(d_reg) << 2);
            rhs_reg <= CMPW'(tn);
        end
        if (stage_reg[2])
        begin
            alert_reg <= lhs_reg > rhs_reg;
        end
    end

    always_comb
    begin
        res.done   = stage_reg[3];
        res.alert  = alert_reg;
        res.spread = (d_reg > DW'(wrsd_pkg::SPREAD_MAX)) ? wrsd_pkg::SPREAD_MAX
                                                          : d_reg[19:0];
    end

endmodule

// ----- src/windowed_rssi_spread_detector.sv -----
// top level of the windowed rssi spread detector
//
// Readings enter on the input channel (rssi, last) with in_valid/in_stall;
// one result per reporting scan leaves on the output channel with
// out_valid/out_stall. Registers are written through cfg_valid/cfg_ready,
// cfg_index selects the threshold (0) or the calibration scan count (1).
// A reading without last leaves the input free and the next beat follows at once.
// A scan-end beat holds the input through the read-modify-write of the window
// ram and the running sums, the multiply and compare stages, and the load of
// the output register. A scan end with no valid window entry gives no result
// and releases the input once the window update is done.
// The output register keeps its beat while out_stall is high; input beats
// without last are still taken, a scan-end beat waits at its last step
// until the output register is free.
// Reset clears the window (per-entry valid bits), the sums, the pointer,
// the scan peak and calibration, and loads the register reset values.
module windowed_rssi_spread_detector #(
    parameter int WINDOW = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [7:0]                 rssi,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [7:0]                 scan_max,
    output logic signed [11:0]                window_sum,
    output logic [3:0]                        valid_count,
    output logic [19:0]                       spread,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wrsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [9:0]                        cfg_data
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SUMW = 8 + CW;
    localparam int SQW = 14 + CW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WIN  = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic signed [7:0]      peak_reg;
    logic signed [7:0]      hold_peak_reg;
    logic [9:0]             thr_reg;
    logic [7:0]             cal_scans_reg;
    logic                   cal_reg;
    logic [7:0]             cal_cnt_reg;
    logic                   out_valid_reg;
    wrsd_pkg::status_t      status_reg;
    logic signed [7:0]      scan_max_reg;
    logic signed [11:0]     window_sum_reg;
    logic [3:0]             valid_count_reg;
    logic [19:0]            spread_reg;

    logic                   in_accept;
    logic                   out_load;
    logic signed [7:0]      final_peak;
    wrsd_pkg::win_ctl_t     win_ctl;
    logic                   win_done;
    logic [CW-1:0]          win_count;
    logic signed [SUMW-1:0] win_sum;
    logic [SQW-1:0]         win_sq;
    logic                   eval_start;
    wrsd_pkg::eval_res_t    eval_res;
    logic [7:0]             cal_cnt_next;
    logic signed [31:0]     sum_wide;
    logic signed [11:0]     sum_sat;
    logic [7:0]             cnt_wide;
    wrsd_pkg::status_t      status_new;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign final_peak = (rssi > peak_reg) ? rssi : peak_reg;

    always_comb
    begin
        win_ctl.start = in_accept && last;
        win_ctl.peak  = final_peak;
    end

    assign eval_start = (state_reg == ST_WIN) && win_done && (win_count != '0);

    wrsd_window #(
        .WINDOW(WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .done  (win_done),
        .count (win_count),
        .sum   (win_sum),
        .sq    (win_sq)
    );

    wrsd_eval #(
        .WINDOW(WINDOW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eval_start),
        .count     (win_count),
        .sum       (win_sum),
        .sq        (win_sq),
        .threshold (thr_reg),
        .res       (eval_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last)
                begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                if (win_done)
                begin
                    state_next = (win_count == '0) ? ST_IDLE : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (eval_res.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cal_cnt_next = (cal_cnt_reg == 8'hFF) ? cal_cnt_reg : cal_cnt_reg + 8'd1;
        sum_wide     = 32'(win_sum);
        if (sum_wide > 32'sd2047)
        begin
            sum_sat = 12'sd2047;
        end
        else if (sum_wide < -32'sd2048)
        begin
            sum_sat = -12'sd2048;
        end
        else
        begin
            sum_sat = sum_wide[11:0];
        end
        cnt_wide = 8'(win_count);
        if (cal_reg)
        begin
            status_new = wrsd_pkg::STATUS_CAL;
        end
        else if (eval_res.alert)
        begin
            status_new = wrsd_pkg::STATUS_ALERT;
        end
        else
        begin
            status_new = wrsd_pkg::STATUS_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= wrsd_pkg::RSSI_FLOOR;
            thr_reg       <= wrsd_pkg::THRESHOLD_RST;
            cal_scans_reg <= wrsd_pkg::CAL_SCANS_RST;
            cal_reg       <= 1'b1;
            cal_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                peak_reg <= last ? wrsd_pkg::RSSI_FLOOR : final_peak;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wrsd_pkg::CFG_THRESHOLD_TENTHS:  thr_reg       <= cfg_data;
                    wrsd_pkg::CFG_CALIBRATION_SCANS: cal_scans_reg <= cfg_data[7:0];
                    default:                         thr_reg       <= thr_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (cal_reg)
                begin
                    cal_cnt_reg <= cal_cnt_next;
                    if (cal_cnt_next >= cal_scans_reg)
                    begin
                        cal_reg <= 1'b0;
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last)
        begin
            hold_peak_reg <= final_peak;
        end
        if (out_load)
        begin
            status_reg      <= status_new;
            scan_max_reg    <= hold_peak_reg;
            window_sum_reg  <= sum_sat;
            valid_count_reg <= (cnt_wide > 8'd15) ? 4'd15 : cnt_wide[3:0];
            spread_reg      <= eval_res.spread;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign scan_max    = scan_max_reg;
    assign window_sum  = window_sum_reg;
    assign valid_count = valid_count_reg;
    assign spread      = spread_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the windowed rssi spread detector
module testbench;

    localparam int WIN_DEPTH = 15;
    localparam int FLOOR_DBM = int'(wrsd_pkg::RSSI_FLOOR);
    localparam int SCAN_LATENCY = 8;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 290;

    typedef struct {
        logic signed [7:0] rssi;
        logic              last;
    } reading_t;

    typedef struct {
        wrsd_pkg::status_t  status;
        logic signed [7:0]  scan_max;
        logic signed [11:0] window_sum;
        logic [3:0]         valid_count;
        logic [19:0]        spread;
    } scan_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [7:0] rssi = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [7:0] scan_max;
    logic signed [11:0] window_sum;
    logic [3:0] valid_count;
    logic [19:0] spread;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wrsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    windowed_rssi_spread_detector #(.WINDOW(WIN_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rssi(rssi),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .scan_max(scan_max),
        .window_sum(window_sum),
        .valid_count(valid_count),
        .spread(spread),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // stimulus and expectations
    reading_t pending_readings[$];
    scan_report_t expected_reports[$];

    // predictor state
    int win_m[WIN_DEPTH] = '{default: FLOOR_DBM};
    int wr_ptr_m = 0;
    int scan_peak_m = FLOOR_DBM;
    bit cal_on_m = 1'b1;
    int cal_cnt_m = 0;
    int thr_m = int'(wrsd_pkg::THRESHOLD_RST);
    int cal_scans_m = int'(wrsd_pkg::CAL_SCANS_RST);

    // pacing controls set by the sequence
    int gap_max = 0;
    int stall_max = 0;
    int hold_requests = 0;

    // handshake flags seen at the last rising edge
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;

    int errors = 0;
    int readings_sent = 0;
    int reports_checked = 0;
    int alerts_seen = 0;
    int cal_seen = 0;
    int settings_used = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    task automatic advance_scan(input logic signed [7:0] r_in, input logic last_in);
        int r;
        int pk;
        int s1;
        int s2;
        int n;
        longint d;
        longint t;
        scan_report_t rep;
        r = int'(r_in);
        if (r > scan_peak_m)
            scan_peak_m = r;
        if (!last_in)
            return;
        pk = scan_peak_m;
        scan_peak_m = FLOOR_DBM;
        win_m[wr_ptr_m] = pk;
        wr_ptr_m = (wr_ptr_m + 1) % WIN_DEPTH;
        s1 = 0;
        s2 = 0;
        n = 0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if (win_m[i] > FLOOR_DBM)
            begin
                s1 += win_m[i];
                s2 += win_m[i] * win_m[i];
                n++;
            end
        end
        // window with no valid entry gives no report
        if (n == 0)
            return;
        d = longint'(n) * s2 - longint'(s1) * s1;
        if (d < 0)
            d = 0;
        if (cal_on_m)
        begin
            rep.status = wrsd_pkg::STATUS_CAL;
            if (cal_cnt_m < 255)
                cal_cnt_m++;
            if (cal_cnt_m >= cal_scans_m)
                cal_on_m = 1'b0;
        end
        else
        begin
            t = thr_m;
            // compare against sigma without the square root
            rep.status = (100 * d > t * t * n * n) ? wrsd_pkg::STATUS_ALERT
                                                   : wrsd_pkg::STATUS_NORMAL;
        end
        rep.scan_max = 8'(pk);
        rep.window_sum = (s1 > 2047) ? 12'sd2047 : (s1 < -2048) ? -12'sd2048 : 12'(s1);
        rep.valid_count = (n > 15) ? 4'd15 : 4'(n);
        rep.spread = (d > longint'(wrsd_pkg::SPREAD_MAX)) ? wrsd_pkg::SPREAD_MAX : 20'(d);
        expected_reports.push_back(rep);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // monitor: register writes, input beats and report beats
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == wrsd_pkg::CFG_THRESHOLD_TENTHS)
                    thr_m = int'(cfg_data);
                else if (cfg_index == wrsd_pkg::CFG_CALIBRATION_SCANS)
                    cal_scans_m = int'(cfg_data[7:0]);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected report, expected nothing, got status %0d max %0d",
                             $time, status, scan_max);
                end
                else
                begin
                    scan_report_t rep;
                    rep = expected_reports.pop_front();
                    check_field("status", int'(rep.status), int'(status));
                    check_field("scan_max", int'(rep.scan_max), int'(scan_max));
                    check_field("window_sum", int'(rep.window_sum), int'(window_sum));
                    check_field("valid_count", int'(rep.valid_count), int'(valid_count));
                    check_field("spread", int'(rep.spread), int'(spread));
                    reports_checked++;
                    if (rep.status == wrsd_pkg::STATUS_ALERT)
                        alerts_seen++;
                    if (rep.status == wrsd_pkg::STATUS_CAL)
                        cal_seen++;
                end
            end
            if (in_valid && !in_stall)
            begin
                readings_sent++;
                advance_scan(rssi, last);
            end
        end
    end

    // driver: one reading per beat, random gap before each
    int gap_left = 0;
    bit gap_drawn = 1'b0;
    reading_t next_rd;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_readings.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                if (!gap_drawn)
                begin
                    gap_left = int'($urandom_range(0, gap_max));
                    gap_drawn = 1'b1;
                end
                if (gap_left == 0)
                begin
                    next_rd = pending_readings.pop_front();
                    in_valid <= 1'b1;
                    rssi <= next_rd.rssi;
                    last <= next_rd.last;
                    gap_drawn = 1'b0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
            end
        end
    end

    // receiver stall: random per report, plus a long hold on request
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (holds_done < hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (out_taken)
                    stall_left = int'($urandom_range(0, stall_max));
                if (stall_left > 0)
                begin
                    out_stall <= 1'b1;
                    stall_left--;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic push_reading(input int v, input bit l);
        reading_t rd;
        rd.rssi = 8'(v);
        rd.last = l;
        pending_readings.push_back(rd);
    endtask

    // block until every queued reading is taken and every report is back
    task automatic wait_all_reported();
        do
            @(posedge clk);
        while (pending_readings.size() != 0 || in_valid || expected_reports.size() != 0);
        // a scan end with an empty window may still be in flight
        repeat (SCAN_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wrsd_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 10'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one scan of len readings around center; sub_floor keeps it invalid
    task automatic queue_scan(input int center, input int jit, input int len, input bit sub_floor);
        int v;
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (sub_floor)
                v = -int'($urandom_range(128, 100));
            else if (pick < 85)
                v = center + int'($urandom_range(0, 2 * jit)) - jit;
            else if (pick < 95)
                v = -int'($urandom_range(128, 0));
            else
                v = -int'($urandom_range(128, 100));
            if (v > 0)
                v = 0;
            if (v < -128)
                v = -128;
            push_reading(v, i == len - 1);
        end
    endtask

    task automatic run_phase(input int thr, input int cal, input int gmax, input int smax,
                             input bit long_hold, input bit drain, input int jit_in);
        int queued;
        int center;
        int jit;
        int len;
        bit drained;
        wait_all_reported();
        write_reg(wrsd_pkg::CFG_THRESHOLD_TENTHS, thr);
        write_reg(wrsd_pkg::CFG_CALIBRATION_SCANS, cal);
        settings_used++;
        gap_max = gmax;
        stall_max = smax;
        if (long_hold)
            hold_requests++;
        jit = (jit_in < 0) ? int'($urandom_range(0, 25)) : jit_in;
        center = -int'($urandom_range(95, 20));
        queued = 0;
        drained = 1'b0;
        while (queued < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                center = -int'($urandom_range(95, 20));
            // run enough dead scans to empty the whole window
            if (drain && !drained && queued > PHASE_ITEMS / 2)
            begin
                for (int k = 0; k < WIN_DEPTH + 2; k++)
                begin
                    queue_scan(center, jit, 1, 1'b1);
                    queued++;
                end
                drained = 1'b1;
            end
            len = ($urandom_range(0, 3) != 0) ? int'($urandom_range(1, 5))
                                               : int'($urandom_range(6, 14));
            queue_scan(center, jit, len, $urandom_range(0, 19) == 0);
            queued += len;
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: calibration count 0 still gives one calibrating scan
        write_reg(wrsd_pkg::CFG_THRESHOLD_TENTHS, 0);
        write_reg(wrsd_pkg::CFG_CALIBRATION_SCANS, 0);
        settings_used++;
        gap_max = 19;
        stall_max = 19;
        // scan ends into an empty window give no report
        push_reading(-128, 1'b1);
        push_reading(-100, 1'b1);
        push_reading(-128, 1'b0);
        push_reading(-1, 1'b0);
        push_reading(0, 1'b1);
        push_reading(-50, 1'b0);
        push_reading(-127, 1'b1);
        // positive readings count as valid
        push_reading(127, 1'b1);
        push_reading(-30, 1'b0);
        push_reading(-70, 1'b0);
        push_reading(-90, 1'b1);
        // alternating extremes drive the spread into saturation
        for (int k = 0; k < 4; k++)
        begin
            push_reading(-99, 1'b1);
            push_reading(127, 1'b1);
        end
        push_reading(-100, 1'b0);
        push_reading(-99, 1'b1);

        run_phase(int'(wrsd_pkg::THRESHOLD_RST), int'(wrsd_pkg::CAL_SCANS_RST),
                  19, 19, 1'b0, 1'b0, -1);
        run_phase(1000, 255, 0, 0, 1'b1, 1'b0, -1);
        run_phase(0, 0, 19, 0, 1'b0, 1'b1, 0);
        run_phase(int'($urandom_range(0, 200)), int'($urandom_range(0, 255)),
                  0, 19, 1'b0, 1'b0, -1);
        run_phase(1, 1, 19, 19, 1'b0, 1'b1, -1);
        run_phase(45, 128, 0, 0, 1'b1, 1'b0, -1);

        // final drain, bounded
        for (int k = 0; k < 20000; k++)
        begin
            if (pending_readings.size() == 0 && !in_valid && expected_reports.size() == 0)
                break;
            @(posedge clk);
        end
        repeat (SCAN_LATENCY + 4) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            errors += expected_reports.size();
            $display("%0t: %0d scan reports never arrived, expected 0 outstanding, got %0d",
                     $time, expected_reports.size(), expected_reports.size());
        end

        $display("%0d readings sent, %0d scan reports checked (%0d calibrating, %0d alerts)",
                 readings_sent, reports_checked, cal_seen, alerts_seen);
        $display("%0d register settings visited, threshold and calibration extremes included",
                 settings_used);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
